FILE: rtl/spfg_pkg.sv
`timescale 1ns / 1ps

package spfg_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int LEVEL_BITS_DEF  = 16;

  localparam int FADE_W = 16;
  localparam logic [FADE_W-1:0] FADE_FRAMES_RESET = 16'd2048;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_FADE_FRAMES  = 1'b0,
    REG_START_PAUSED = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEFT_GO,
    S_LEFT,
    S_RIGHT,
    S_FIN
  } seq_state_t;

  typedef enum logic {
    U_IDLE,
    U_DIV
  } unit_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } scale_stat_t;

endpackage

FILE: rtl/spfg_if.sv
`timescale 1ns / 1ps

interface spfg_frame_if #(
  parameter int SAMPLE_BITS = spfg_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          pause;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          buffer_end;

  modport source (output valid, pause, left_in, right_in, buffer_end, input ready);
  modport sink   (input valid, pause, left_in, right_in, buffer_end, output ready);
endinterface

interface spfg_result_if #(
  parameter int SAMPLE_BITS = spfg_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          consumed;
  logic                          buffer_end_out;

  modport source (output valid, left_out, right_out, consumed, buffer_end_out, input ready);
  modport sink   (input valid, left_out, right_out, consumed, buffer_end_out, output ready);
endinterface

FILE: rtl/spfg_scale.sv
`timescale 1ns / 1ps

// sample * level / len, truncating toward zero
// the multiply is registered into the divider registers, then one quotient bit per cycle
module spfg_scale #(
  parameter int SAMPLE_BITS = spfg_pkg::SAMPLE_BITS_DEF,
  parameter int LEVEL_BITS  = spfg_pkg::LEVEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic        [LEVEL_BITS-1:0]  level,
  input  logic        [LEVEL_BITS-1:0]  len,
  output spfg_pkg::scale_stat_t         stat,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int PW = SAMPLE_BITS + LEVEL_BITS;
  localparam int CW = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;

  spfg_pkg::unit_state_t state, state_next;

  logic                   neg;
  logic [LEVEL_BITS-1:0]  rem;
  logic [SAMPLE_BITS-1:0] quo;
  logic [CW-1:0]          cnt;
  logic                   done;

  logic [SAMPLE_BITS-1:0] mag;
  logic [PW-1:0]          prod;
  logic [LEVEL_BITS:0]    trial;
  logic                   fits;
  logic                   last;

  assign mag   = sample[SAMPLE_BITS-1] ? (~sample + SAMPLE_BITS'(1)) : sample;
  assign prod  = PW'(mag) * PW'(level);
  assign trial = {rem, quo[SAMPLE_BITS-1]};
  assign fits  = trial >= {1'b0, len};
  assign last  = cnt == CW'(SAMPLE_BITS - 1);

  always_comb begin
    state_next = state;
    case (state)
      spfg_pkg::U_IDLE: if (start) state_next = spfg_pkg::U_DIV;
      spfg_pkg::U_DIV:  if (last) state_next = spfg_pkg::U_IDLE;
      default:          state_next = spfg_pkg::U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spfg_pkg::U_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == spfg_pkg::U_DIV) && last;
    end
  end

  // the upper product part is below len since level <= len
  always_ff @(posedge clk) begin
    if (state == spfg_pkg::U_IDLE && start) begin
      neg <= sample[SAMPLE_BITS-1];
      rem <= prod[PW-1:SAMPLE_BITS];
      quo <= prod[SAMPLE_BITS-1:0];
      cnt <= '0;
    end else if (state == spfg_pkg::U_DIV) begin
      rem <= fits ? LEVEL_BITS'(trial - {1'b0, len}) : trial[LEVEL_BITS-1:0];
      quo <= {quo[SAMPLE_BITS-2:0], fits};
      cnt <= cnt + CW'(1);
    end
  end

  assign result    = neg ? (~quo + SAMPLE_BITS'(1)) : quo;
  assign stat.busy = state != spfg_pkg::U_IDLE;
  assign stat.done = done;

endmodule

FILE: rtl/stereo_pause_fade_gain.sv
`timescale 1ns / 1ps

// channel  dir  handshake          payload
// frame    in   valid/ready        pause, left_in, right_in, buffer_end
// result   out  valid/ready        left_out, right_out, consumed, buffer_end_out
// apb      in   psel/penable       fade_frames (0x0), start_paused (0x4)
//
// a frame from accept to result goes through the one scale unit,
// which divides each channel in turn a bit per cycle
// a silent frame (paused at level zero) skips the scale unit and goes to the output step
// rst is synchronous; it restores the state, configuration and result valid and reloads the fade level
// a new frame is taken while a result still waits; the sequencer holds the
// next result until the output register is free
module stereo_pause_fade_gain #(
  parameter int SAMPLE_BITS = spfg_pkg::SAMPLE_BITS_DEF,
  parameter int LEVEL_BITS  = spfg_pkg::LEVEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  spfg_frame_if.sink                    frame,
  spfg_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spfg_pkg::APB_AW-1:0]   paddr,
  input  logic [spfg_pkg::APB_DW-1:0]   pwdata,
  output logic [spfg_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int FW    = spfg_pkg::FADE_W;
  localparam int CMP_W = (LEVEL_BITS > FW) ? LEVEL_BITS : FW;
  localparam logic [CMP_W-1:0] LMAX = CMP_W'((64'(1) << LEVEL_BITS) - 64'(1));
  localparam logic [CMP_W-1:0] RESET_EXT = CMP_W'(spfg_pkg::FADE_FRAMES_RESET);
  localparam logic [LEVEL_BITS-1:0] RESET_LEN =
    (RESET_EXT > LMAX) ? LMAX[LEVEL_BITS-1:0] : RESET_EXT[LEVEL_BITS-1:0];

  function automatic logic [LEVEL_BITS-1:0] len_of(input logic [FW-1:0] ff);
    logic [CMP_W-1:0] e;
    e = CMP_W'(ff);
    if (e > LMAX) e = LMAX;
    if (e == '0) e = CMP_W'(1);
    return e[LEVEL_BITS-1:0];
  endfunction

  // configuration
  logic [FW-1:0]         fade_frames;
  logic                  start_paused;
  logic [FW-1:0]         fade_frames_next;
  logic                  start_paused_next;
  logic                  cfg_wr;
  spfg_pkg::reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = spfg_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    fade_frames_next  = fade_frames;
    start_paused_next = start_paused;
    case (cfg_idx)
      spfg_pkg::REG_FADE_FRAMES:  fade_frames_next  = pwdata[FW-1:0];
      spfg_pkg::REG_START_PAUSED: start_paused_next = pwdata[0];
      default: ;
    endcase
  end

  always_comb begin
    case (cfg_idx)
      spfg_pkg::REG_FADE_FRAMES:  prdata = spfg_pkg::APB_DW'(fade_frames);
      spfg_pkg::REG_START_PAUSED: prdata = spfg_pkg::APB_DW'(start_paused);
      default:                    prdata = '0;
    endcase
  end

  // sequencer
  spfg_pkg::seq_state_t state, state_next;
  spfg_pkg::scale_stat_t ustat;

  logic [LEVEL_BITS-1:0]         fade_level;
  logic [LEVEL_BITS-1:0]         eff_len;
  logic [LEVEL_BITS-1:0]         lvl_c;
  logic [LEVEL_BITS-1:0]         lvl;
  logic                          silent;
  logic                          accept;
  logic                          out_free;
  logic                          ustart;
  logic signed [SAMPLE_BITS-1:0] usample;
  logic signed [SAMPLE_BITS-1:0] uresult;

  logic signed [SAMPLE_BITS-1:0] left_q;
  logic signed [SAMPLE_BITS-1:0] right_q;
  logic                          bend_q;
  logic                          silent_q;

  assign eff_len  = len_of(fade_frames);
  assign lvl_c    = (fade_level > eff_len) ? eff_len : fade_level;
  assign silent   = frame.pause && (lvl_c == '0);
  assign frame.ready = state == spfg_pkg::S_IDLE;
  assign accept   = frame.valid && frame.ready;
  assign out_free = !result.valid || result.ready;
  assign usample  = (state == spfg_pkg::S_LEFT_GO) ? left_q : right_q;

  always_comb begin
    state_next = state;
    ustart     = 1'b0;
    case (state)
      spfg_pkg::S_IDLE:
        if (accept) state_next = silent ? spfg_pkg::S_FIN : spfg_pkg::S_LEFT_GO;
      spfg_pkg::S_LEFT_GO: begin
        ustart     = 1'b1;
        state_next = spfg_pkg::S_LEFT;
      end
      spfg_pkg::S_LEFT:
        if (ustat.done) begin
          ustart     = 1'b1;
          state_next = spfg_pkg::S_RIGHT;
        end
      spfg_pkg::S_RIGHT:
        if (ustat.done) state_next = spfg_pkg::S_FIN;
      spfg_pkg::S_FIN:
        if (out_free) state_next = spfg_pkg::S_IDLE;
      default: state_next = spfg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= spfg_pkg::S_IDLE;
      fade_frames  <= spfg_pkg::FADE_FRAMES_RESET;
      start_paused <= 1'b0;
      fade_level   <= RESET_LEN;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        fade_frames  <= fade_frames_next;
        start_paused <= start_paused_next;
        fade_level   <= start_paused_next ? '0 : len_of(fade_frames_next);
      end else if (accept) begin
        if (frame.pause)
          fade_level <= silent ? '0 : lvl_c - LEVEL_BITS'(1);
        else if (lvl_c < eff_len)
          fade_level <= lvl_c + LEVEL_BITS'(1);
        else
          fade_level <= lvl_c;
      end
      if (state == spfg_pkg::S_FIN && out_free)
        result.valid <= 1'b1;
      else if (result.ready)
        result.valid <= 1'b0;
    end
  end

  // beat payload and scaled results
  always_ff @(posedge clk) begin
    if (accept) begin
      left_q   <= frame.left_in;
      right_q  <= frame.right_in;
      bend_q   <= frame.buffer_end;
      silent_q <= silent;
      lvl      <= lvl_c;
    end
    if (state == spfg_pkg::S_LEFT && ustat.done) left_q <= uresult;
    if (state == spfg_pkg::S_RIGHT && ustat.done) right_q <= uresult;
    if (state == spfg_pkg::S_FIN && out_free) begin
      result.left_out       <= silent_q ? '0 : left_q;
      result.right_out      <= silent_q ? '0 : right_q;
      result.consumed       <= !silent_q;
      result.buffer_end_out <= bend_q;
    end
  end

  spfg_scale #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .LEVEL_BITS  (LEVEL_BITS)
  ) u_scale (
    .clk    (clk),
    .rst    (rst),
    .start  (ustart),
    .sample (usample),
    .level  (lvl),
    .len    (eff_len),
    .stat   (ustat),
    .result (uresult)
  );

`ifndef SYNTHESIS
  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    fade_level <= eff_len)
    else $error("fade level above fade length");

  a_done_when_waited: assert property (@(posedge clk) disable iff (rst)
    ustat.done |-> (state == spfg_pkg::S_LEFT || state == spfg_pkg::S_RIGHT))
    else $error("scale unit finished outside a channel step");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    ustart |-> !ustat.busy)
    else $error("scale unit started while busy");

  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.consumed) |->
      (result.left_out == '0 && result.right_out == '0))
    else $error("silent beat carries nonzero samples");
`endif

endmodule

FILE: test/stereo_pause_fade_gain_tb.sv
`timescale 1ns / 1ps

module stereo_pause_fade_gain_tb;

  localparam int SW = spfg_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned LVL_MAX = (1 << spfg_pkg::LEVEL_BITS_DEF) - 1;
  localparam longint SMAX = (longint'(1) << (SW - 1)) - 1;
  localparam longint SMIN = -(longint'(1) << (SW - 1));
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic                 pause;
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic                 last;
  } frame_beat_t;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic                 consumed;
    logic                 last;
  } gain_beat_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [spfg_pkg::APB_AW-1:0] paddr;
  logic [spfg_pkg::APB_DW-1:0] pwdata;
  logic [spfg_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  spfg_frame_if  #(.SAMPLE_BITS(SW)) frame_ch ();
  spfg_result_if #(.SAMPLE_BITS(SW)) result_ch ();

  stereo_pause_fade_gain #(
    .SAMPLE_BITS(SW),
    .LEVEL_BITS (spfg_pkg::LEVEL_BITS_DEF)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_ch),
    .result (result_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #1 clk = ~clk;

  // predictor state
  int unsigned cfg_frames;
  bit          cfg_start_paused;
  int unsigned fade_lvl;

  frame_beat_t frames_to_send[$];
  gain_beat_t  gain_expected[$];
  int          frames_queued = 0;
  int          results_seen = 0;
  int          mismatch_count = 0;
  bit          frame_took = 1'b0;
  int          quiet = 0;
  int          holds_asked = 0;
  int          holds_started = 0;

  function automatic int unsigned fade_len();
    int unsigned len;
    len = cfg_frames;
    if (len > LVL_MAX) len = LVL_MAX;
    if (len == 0) len = 1;
    return len;
  endfunction

  function automatic void reload_fade();
    fade_lvl = cfg_start_paused ? 0 : fade_len();
  endfunction

  function automatic logic [SW-1:0] scale_sample(logic signed [SW-1:0] s, int unsigned lvl,
                                                 int unsigned len);
    longint q;
    q = (longint'(s) * longint'(lvl)) / longint'(len);
    if (q > SMAX) q = SMAX;
    if (q < SMIN) q = SMIN;
    return q[SW-1:0];
  endfunction

  // gain uses the level before this frame's step
  function automatic gain_beat_t fade_gain_predict(frame_beat_t f);
    gain_beat_t  r;
    int unsigned len;
    int unsigned lvl;
    len = fade_len();
    lvl = fade_lvl;
    if (lvl > len) lvl = len;
    r.last = f.last;
    if (f.pause && lvl == 0) begin
      r.left = '0;
      r.right = '0;
      r.consumed = 1'b0;
      fade_lvl = 0;
      return r;
    end
    r.left = scale_sample(f.left, lvl, len);
    r.right = scale_sample(f.right, lvl, len);
    r.consumed = 1'b1;
    if (f.pause) lvl = lvl - 1;
    else if (lvl < len) lvl = lvl + 1;
    fade_lvl = lvl & LVL_MAX;
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatch_count < 100) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic apb_write(spfg_pkg::reg_idx_t idx, logic [spfg_pkg::APB_DW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == spfg_pkg::REG_FADE_FRAMES) cfg_frames = data[15:0];
    else cfg_start_paused = data[0];
    reload_fade();
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (results_seen != frames_queued) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic queue_frame(logic p, logic [SW-1:0] l, logic [SW-1:0] r, logic last);
    frame_beat_t b;
    b.pause = p;
    b.left = l;
    b.right = r;
    b.last = last;
    frames_to_send.push_back(b);
    frames_queued++;
  endtask

  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(SW-1){1'b1}}};
      1: return {1'b1, {(SW-1){1'b0}}};
      2: return '0;
      3: return SW'($signed($urandom_range(0, 6)) - 3);
      default: return SW'($urandom());
    endcase
  endfunction

  task automatic queue_random(logic p);
    queue_frame(p, rand_sample(), rand_sample(), $urandom_range(0, 7) == 0);
  endtask

  // mostly clean play/pause runs that sweep the level, plus lone flips and noise
  task automatic gen_frames(int n, int unsigned len);
    int   done;
    int   run;
    int   k;
    logic p;
    done = 0;
    p = 1'($urandom_range(0, 1));
    while (done < n) begin
      case ($urandom_range(0, 9))
        7: begin
          run = 1;
          queue_random(~p);
        end
        8: begin
          p = 1'b1;
          run = (len <= 30) ? len + $urandom_range(1, 6) : $urandom_range(1, 10);
          for (k = 0; k < run; k++) queue_random(p);
        end
        9: begin
          run = $urandom_range(2, 8);
          for (k = 0; k < run; k++) queue_random(1'($urandom_range(0, 1)));
        end
        default: begin
          p = ~p;
          run = $urandom_range(1, ((len < 40) ? len : 40) + 3);
          for (k = 0; k < run; k++) queue_random(p);
        end
      endcase
      done += run;
    end
  endtask

  // sender: bursts with random gaps
  int gap_left = 0;
  int burst_left = 0;

  always @(negedge clk) begin : drive
    logic        nv;
    frame_beat_t b;
    nv = frame_ch.valid;
    if (frame_took) begin
      nv = 1'b0;
      frame_took = 1'b0;
    end
    if (rst) begin
      nv = 1'b0;
    end else if (!nv) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (frames_to_send.size() > 0) begin
        b = frames_to_send.pop_front();
        frame_ch.pause <= b.pause;
        frame_ch.left_in <= b.left;
        frame_ch.right_in <= b.right;
        frame_ch.buffer_end <= b.last;
        nv = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          case ($urandom_range(0, 3))
            0: begin
              burst_left = $urandom_range(20, 60);
              gap_left = 0;
            end
            1: begin
              burst_left = $urandom_range(1, 8);
              gap_left = $urandom_range(1, 5);
            end
            2: begin
              burst_left = $urandom_range(1, 4);
              gap_left = $urandom_range(10, 45);
            end
            default: begin
              burst_left = $urandom_range(1, 3);
              gap_left = $urandom_range(0, 2);
            end
          endcase
        end
      end
    end
    frame_ch.valid <= nv;
  end

  // receiver: stall pattern that changes mode now and then, plus requested long holds
  int rx_mode = 0;
  int rx_left = 0;
  int rx_tick = 0;
  int hold_left = 0;

  always @(negedge clk) begin : recv
    logic nr;
    if (rst) begin
      nr = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      nr = 1'b0;
    end else if (holds_started != holds_asked) begin
      holds_started++;
      hold_left = LONG_HOLD - 1;
      nr = 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 300);
      end else begin
        rx_left--;
      end
      rx_tick++;
      case (rx_mode)
        0: nr = 1'b1;
        1: nr = 1'($urandom_range(0, 1));
        2: nr = ($urandom_range(0, 4) == 0);
        default: nr = (rx_tick % 7) < 3;
      endcase
    end
    result_ch.ready <= nr;
  end

  // monitor: predicts on each accepted frame, checks each accepted result
  always @(posedge clk) begin : watch
    frame_beat_t fb;
    gain_beat_t  got;
    gain_beat_t  want;
    bit          beat;
    beat = 1'b0;
    if (!rst) begin
      if (frame_ch.valid && frame_ch.ready) begin
        fb.pause = frame_ch.pause;
        fb.left = frame_ch.left_in;
        fb.right = frame_ch.right_in;
        fb.last = frame_ch.buffer_end;
        gain_expected.push_back(fade_gain_predict(fb));
        frame_took = 1'b1;
        beat = 1'b1;
      end
      if (result_ch.valid && result_ch.ready) begin
        beat = 1'b1;
        results_seen++;
        got.left = result_ch.left_out;
        got.right = result_ch.right_out;
        got.consumed = result_ch.consumed;
        got.last = result_ch.buffer_end_out;
        if (gain_expected.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing expected (l=%0d r=%0d)",
                                  got.left, got.right));
        end else begin
          want = gain_expected.pop_front();
          if (got.left !== want.left)
            flag_mismatch($sformatf("left_out %0d, want %0d", got.left, want.left));
          if (got.right !== want.right)
            flag_mismatch($sformatf("right_out %0d, want %0d", got.right, want.right));
          if (got.consumed !== want.consumed)
            flag_mismatch($sformatf("consumed %0b, want %0b", got.consumed, want.consumed));
          if (got.last !== want.last)
            flag_mismatch($sformatf("buffer_end_out %0b, want %0b", got.last, want.last));
        end
      end
      if (psel && penable && pwrite && pready) beat = 1'b1;
    end
    quiet = beat ? 0 : quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stim
    int          p;
    int unsigned ff;
    bit          sp;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    frame_ch.valid = 1'b0;
    frame_ch.pause = 1'b0;
    frame_ch.left_in = '0;
    frame_ch.right_in = '0;
    frame_ch.buffer_end = 1'b0;
    result_ch.ready = 1'b0;
    cfg_frames = spfg_pkg::FADE_FRAMES_RESET;
    cfg_start_paused = 1'b0;
    reload_fade();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset length, full gain: extremes pass through unchanged
    queue_frame(1'b0, 16'sh7fff, 16'sh8000, 1'b0);
    queue_frame(1'b0, 16'sh8000, 16'sh7fff, 1'b1);
    queue_frame(1'b0, 16'sh0000, 16'shffff, 1'b0);
    wait_drained();

    // short fade from silence: silent frames, ramp up, ramp down to silence
    apb_write(spfg_pkg::REG_FADE_FRAMES, 32'd3);
    apb_write(spfg_pkg::REG_START_PAUSED, 32'd1);
    queue_frame(1'b1, 16'sh7fff, 16'sh8000, 1'b1);
    queue_frame(1'b1, 16'sh1234, 16'shedcb, 1'b0);
    repeat (5) queue_frame(1'b0, 16'sh8000, 16'sh7fff, 1'b0);
    repeat (5) queue_frame(1'b1, 16'sh7fff, 16'sh8001, 1'b1);
    wait_drained();

    // zero length acts as one; level zero while playing still consumes
    apb_write(spfg_pkg::REG_START_PAUSED, 32'd0);
    apb_write(spfg_pkg::REG_FADE_FRAMES, 32'd0);
    queue_frame(1'b0, 16'sh8000, 16'sh7fff, 1'b0);
    queue_frame(1'b1, 16'sh8000, 16'sh7fff, 1'b0);
    queue_frame(1'b1, 16'sh0001, 16'shffff, 1'b1);
    queue_frame(1'b0, 16'sh8000, 16'sh7fff, 1'b0);
    queue_frame(1'b0, 16'sh8000, 16'sh7fff, 1'b0);
    wait_drained();

    // longest fade: tiny gains truncate toward zero
    apb_write(spfg_pkg::REG_FADE_FRAMES, 32'hffff_ffff);
    queue_frame(1'b0, 16'sh7fff, 16'sh8000, 1'b0);
    queue_frame(1'b1, 16'sh8000, 16'sh7fff, 1'b0);
    wait_drained();
    apb_write(spfg_pkg::REG_START_PAUSED, 32'hffff_fff1);
    queue_frame(1'b0, 16'sh7fff, 16'sh8000, 1'b0);
    queue_frame(1'b0, 16'sh8000, 16'sh7fff, 1'b0);
    queue_frame(1'b1, 16'sh7fff, 16'sh8000, 1'b0);
    queue_frame(1'b1, 16'sh7fff, 16'sh8000, 1'b1);

    for (p = 0; p < 15; p++) begin
      wait_drained();
      case (p)
        0: ff = 1;
        1: ff = 65535;
        2: ff = 0;
        3: ff = 2;
        default: ff = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(1, 24);
      endcase
      sp = (p < 4) ? 1'(p % 2) : 1'($urandom_range(0, 1));
      if ($urandom_range(0, 1)) begin
        apb_write(spfg_pkg::REG_FADE_FRAMES, {16'($urandom()), ff[15:0]});
        apb_write(spfg_pkg::REG_START_PAUSED, {31'($urandom()), sp});
      end else begin
        apb_write(spfg_pkg::REG_START_PAUSED, {31'($urandom()), sp});
        apb_write(spfg_pkg::REG_FADE_FRAMES, {16'($urandom()), ff[15:0]});
      end
      if (p == 9) begin
        // sender stops until every result is back
        gen_frames(45, fade_len());
        while (results_seen != frames_queued) @(negedge clk);
        gen_frames(45, fade_len());
      end else begin
        gen_frames(90, fade_len());
      end
      // receiver holds off while frames keep coming
      if (p == 4 || p == 11) holds_asked++;
    end

    while (results_seen != frames_queued) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (gain_expected.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", gain_expected.size()));
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/spfg_pkg.sv
rtl/spfg_if.sv
rtl/spfg_scale.sv
rtl/stereo_pause_fade_gain.sv
test/stereo_pause_fade_gain_tb.sv
